>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the sequencer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hw/rtl/iass_pkg.sv
package iass_pkg;

   // channel count range and default
   localparam int CH_MAX          = 16;
   localparam int CH_W            = 4;
   localparam int NUM_CHANNELS_DEF = 16;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVADDR  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CHMASK   = 3'd7;

   // register reset values
   localparam logic [15:0] TIMEOUT_DEF = 16'd60;
   localparam logic [15:0] SETTLE_DEF  = 16'd35;
   localparam logic [15:0] GAP_DEF     = 16'd47;
   localparam logic [15:0] BACKOFF_DEF = 16'd8000;
   localparam logic [5:0]  RETRY_DEF   = 6'd50;
   localparam logic [7:0]  DEVADDR_DEF = 8'h28;
   localparam logic [7:0]  RATE_DEF    = 8'd1;
   localparam logic [15:0] CHMASK_DEF  = 16'd1;

   // parked channel after reset and after bus recovery
   localparam logic [CH_W-1:0] CH_PARK = 4'd15;
   localparam logic [5:0]      RETRY_SAT = 6'd63;
   localparam logic [1:0]      SAMPLES_SAT = 2'd3;

   typedef enum logic [3:0] {
      PH_GETJOB    = 4'd0,
      PH_GOAGAIN   = 4'd1,
      PH_SENDSTART = 4'd2,
      PH_STARTDONE = 4'd3,
      PH_WRADDR    = 4'd4,
      PH_RDADDR    = 4'd5,
      PH_READ      = 4'd6,
      PH_WAITSTOP  = 4'd7,
      PH_WRRATE    = 4'd8,
      PH_SETTLE    = 4'd9,
      PH_CLEANUP   = 4'd10,
      PH_GAP       = 4'd11,
      PH_BACKOFF   = 4'd12
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_EVAL   = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic search_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_search;
      logic search_hit;
   } ctrl_status_type;

endpackage

>>> hw/rtl/iass_ctrl.sv
`include "assert_macros.svh"

module iass_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  iass_pkg::ctrl_status_type status,
   output iass_pkg::ctrl_cmd_type   cmd
);

   iass_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iass_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.need_search ? iass_pkg::ST_SEARCH : iass_pkg::ST_EVAL;
            end
         end
         iass_pkg::ST_SEARCH: begin
            if (status.search_hit) begin
               state_in = iass_pkg::ST_EVAL;
            end
         end
         iass_pkg::ST_EVAL: begin
            if (out_free) begin
               state_in = iass_pkg::ST_IDLE;
            end
         end
         default: state_in = iass_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load        = (state_ff == iass_pkg::ST_IDLE) && req_valid;
      cmd.search_step = (state_ff == iass_pkg::ST_SEARCH);
      cmd.commit      = (state_ff == iass_pkg::ST_EVAL) && out_free;
      req_stall       = (state_ff != iass_pkg::ST_IDLE);
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iass_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result never overwrites one still waiting
   `ASSERT_PROP(a_commit_room, clock, reset, cmd.commit |-> (!rsp_valid_ff || !rsp_stall), "commit while response held")
   // every commit shows up as a response
   `ASSERT_PROP(a_commit_shows, clock, reset, cmd.commit |=> rsp_valid_ff, "commit lost")

endmodule

>>> hw/rtl/iass_dp.sv
`include "assert_macros.svh"

module iass_dp #(
   parameter int NUM_CHANNELS = iass_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  iass_pkg::ctrl_cmd_type            cmd,
   output iass_pkg::ctrl_status_type         status,
   input  logic                              csr_write_enable,
   input  logic [iass_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [iass_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [31:0]                       req_now_ms,
   input  logic                              req_flag_sb,
   input  logic                              req_flag_msl,
   input  logic                              req_flag_busy,
   input  logic                              req_flag_addr,
   input  logic                              req_flag_txe,
   input  logic                              req_flag_tra,
   input  logic                              req_flag_btf,
   input  logic                              req_flag_stopf,
   input  logic [7:0]                        req_rx_first,
   input  logic [7:0]                        req_rx_second,
   output logic                              rsp_send_start,
   output logic                              rsp_send_stop,
   output logic                              rsp_tx_valid,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_ack_off,
   output logic                              rsp_bus_reset,
   output logic                              rsp_pins_reinit,
   output logic                              rsp_mux_update,
   output logic [iass_pkg::CH_W-1:0]         rsp_mux_channel,
   output logic                              rsp_sample_valid,
   output logic [iass_pkg::CH_W-1:0]         rsp_sample_channel,
   output logic [15:0]                       rsp_sample_value
);

   localparam int CH_W = iass_pkg::CH_W;
   localparam logic [iass_pkg::CH_MAX-1:0] CH_LIVE =
      iass_pkg::CH_MAX'((33'd1 << NUM_CHANNELS) - 33'd1);

   // configuration
   logic [15:0] timeout_ff, settle_ff, gap_ff, backoff_ff, chmask_ff;
   logic [5:0]  retry_limit_ff;
   logic [7:0]  devaddr_ff, rate_ff;

   // sequencer state
   iass_pkg::phase_type phase_ff, phase_in;
   logic [31:0]     start_ff, start_in;
   logic            wop_ff, wop_in;
   logic            jwo_ff, jwo_in;
   logic [1:0]      samples_ff, samples_in;
   logic [5:0]      retry_ff, retry_in;
   logic [CH_W-1:0] active_ff, active_in;
   logic [15:0]     held_ff, held_in;

   // request snapshot
   logic [31:0] now_ff, elapsed_ff;
   logic        sb_ff, msl_ff, busy_ff, addr_ff, txe_ff, tra_ff, btf_ff, stopf_ff;
   logic [7:0]  rx1_ff, rx2_ff;

   // channel search
   logic [CH_W-1:0]             cand_ff, cand_nxt;
   logic [iass_pkg::CH_MAX-1:0] mask_live, mask_eff;

   // response register
   logic            o_start_ff, o_stop_ff, o_txv_ff, o_ack_ff, o_brst_ff, o_pins_ff;
   logic            o_mupd_ff, o_sv_ff;
   logic [7:0]      o_txb_ff;
   logic [CH_W-1:0] o_mch_ff, o_sch_ff;
   logic [15:0]     o_sval_ff;
   logic            o_start_in, o_stop_in, o_txv_in, o_ack_in, o_brst_in, o_pins_in;
   logic            o_mupd_in, o_sv_in;
   logic [7:0]      o_txb_in;
   logic [CH_W-1:0] o_sch_in;
   logic [15:0]     o_sval_in;

   logic [5:0] retry_bump;
   logic       tmo;

   function automatic logic reached(input logic [31:0] el, input logic [15:0] lim);
      reached = (|el[31:16]) || (el[15:0] >= lim);
   endfunction

   // channel search, one candidate per cycle
   assign mask_live = chmask_ff & CH_LIVE;
   assign mask_eff  = (mask_live == '0) ? iass_pkg::CH_MAX'(1) : mask_live;
   assign cand_nxt  = (({1'b0, cand_ff} + 5'd1) >= 5'(NUM_CHANNELS)) ? '0 : cand_ff + 1'b1;

   assign status.search_hit  = mask_eff[cand_nxt];
   assign status.need_search = (phase_ff == iass_pkg::PH_GETJOB);

   assign retry_bump = (retry_ff < iass_pkg::RETRY_SAT) ? retry_ff + 6'd1 : retry_ff;
   assign tmo = (phase_ff != iass_pkg::PH_GETJOB) && (phase_ff < iass_pkg::PH_CLEANUP)
                && reached(elapsed_ff, timeout_ff);

   // one poll step; phases passed in one step all see the same snapshot
   always_comb begin : step
      logic done;
      done       = 1'b0;
      phase_in   = phase_ff;
      start_in   = start_ff;
      wop_in     = wop_ff;
      jwo_in     = jwo_ff;
      samples_in = samples_ff;
      retry_in   = retry_ff;
      active_in  = active_ff;
      held_in    = held_ff;
      o_start_in = 1'b0;
      o_stop_in  = 1'b0;
      o_txv_in   = 1'b0;
      o_txb_in   = '0;
      o_ack_in   = 1'b0;
      o_brst_in  = 1'b0;
      o_pins_in  = 1'b0;
      o_mupd_in  = 1'b0;
      o_sv_in    = 1'b0;
      o_sch_in   = '0;
      o_sval_in  = '0;

      if (tmo) begin
         retry_in  = retry_bump;
         o_brst_in = 1'b1;
         phase_in  = iass_pkg::PH_CLEANUP;
         done      = 1'b1;
      end
      if (!done && phase_in == iass_pkg::PH_GETJOB) begin
         active_in  = cand_ff;
         o_mupd_in  = 1'b1;
         samples_in = '0;
         start_in   = now_ff;
         phase_in   = iass_pkg::PH_GOAGAIN;
      end
      if (!done && phase_in == iass_pkg::PH_GOAGAIN) begin
         jwo_in   = wop_in;
         wop_in   = 1'b0;
         phase_in = iass_pkg::PH_SENDSTART;
      end
      if (!done && phase_in == iass_pkg::PH_SENDSTART) begin
         if (busy_ff) begin
            done = 1'b1;
         end else begin
            phase_in   = iass_pkg::PH_STARTDONE;
            o_start_in = 1'b1;
         end
      end
      if (!done && phase_in == iass_pkg::PH_STARTDONE) begin
         done = 1'b1;
         if (sb_ff && msl_ff && busy_ff) begin
            o_txv_in = 1'b1;
            if (jwo_in) begin
               phase_in = iass_pkg::PH_WRADDR;
               o_txb_in = devaddr_ff;
            end else begin
               phase_in = iass_pkg::PH_RDADDR;
               o_txb_in = devaddr_ff | 8'd1;
            end
         end
      end
      if (!done && phase_in == iass_pkg::PH_WRADDR) begin
         done = 1'b1;
         if (addr_ff && txe_ff && msl_ff && busy_ff && tra_ff) begin
            phase_in = iass_pkg::PH_WRRATE;
            o_txv_in = 1'b1;
            o_txb_in = rate_ff;
         end
      end
      if (!done && phase_in == iass_pkg::PH_RDADDR) begin
         if (!addr_ff) begin
            done = 1'b1;
         end else begin
            phase_in = iass_pkg::PH_READ;
            o_ack_in = 1'b1;
         end
      end
      if (!done && phase_in == iass_pkg::PH_READ) begin
         if (!btf_ff) begin
            done = 1'b1;
         end else begin
            o_stop_in = 1'b1;
            held_in   = {rx1_ff, rx2_ff};
            phase_in  = iass_pkg::PH_WAITSTOP;
         end
      end
      if (!done && phase_in == iass_pkg::PH_WAITSTOP) begin
         done = 1'b1;
         if (!stopf_ff) begin
            start_in = now_ff;
            if (!jwo_in) begin
               if (samples_in < iass_pkg::SAMPLES_SAT) begin
                  samples_in = samples_in + 2'd1;
               end
               if (samples_in == 2'd1) begin
                  // first sample is thrown away, let the mux settle
                  phase_in = iass_pkg::PH_SETTLE;
               end else begin
                  o_sv_in   = 1'b1;
                  o_sch_in  = active_in;
                  o_sval_in = held_in;
                  phase_in  = iass_pkg::PH_GAP;
               end
            end else begin
               phase_in = iass_pkg::PH_GAP;
            end
         end
      end
      if (!done && phase_in == iass_pkg::PH_WRRATE) begin
         done = 1'b1;
         if (btf_ff) begin
            o_stop_in = 1'b1;
            phase_in  = iass_pkg::PH_WAITSTOP;
         end
      end
      if (!done && phase_in == iass_pkg::PH_SETTLE) begin
         done = 1'b1;
         if (reached(elapsed_ff, settle_ff)) begin
            start_in = now_ff;
            phase_in = iass_pkg::PH_GOAGAIN;
         end
      end
      if (!done && phase_in == iass_pkg::PH_GAP) begin
         done = 1'b1;
         if (reached(elapsed_ff, gap_ff)) begin
            phase_in = iass_pkg::PH_GETJOB;
         end
      end
      if (!done && phase_in == iass_pkg::PH_BACKOFF) begin
         done = 1'b1;
         if (reached(elapsed_ff, backoff_ff)) begin
            phase_in = iass_pkg::PH_GETJOB;
         end
      end
      if (!done && phase_in == iass_pkg::PH_CLEANUP) begin
         o_pins_in = 1'b1;
         if ((retry_ff < retry_limit_ff) && busy_ff) begin
            retry_in  = retry_bump;
            o_brst_in = 1'b1;
         end else begin
            phase_in = iass_pkg::PH_GETJOB;
            if (retry_ff == retry_limit_ff) begin
               start_in = now_ff;
               phase_in = iass_pkg::PH_BACKOFF;
            end
            retry_in  = '0;
            active_in = iass_pkg::CH_PARK;
            wop_in    = 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= iass_pkg::TIMEOUT_DEF;
         settle_ff      <= iass_pkg::SETTLE_DEF;
         gap_ff         <= iass_pkg::GAP_DEF;
         backoff_ff     <= iass_pkg::BACKOFF_DEF;
         retry_limit_ff <= iass_pkg::RETRY_DEF;
         devaddr_ff     <= iass_pkg::DEVADDR_DEF;
         rate_ff        <= iass_pkg::RATE_DEF;
         chmask_ff      <= iass_pkg::CHMASK_DEF;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            iass_pkg::CSR_TIMEOUT: timeout_ff     <= csr_write_data;
            iass_pkg::CSR_SETTLE:  settle_ff      <= csr_write_data;
            iass_pkg::CSR_GAP:     gap_ff         <= csr_write_data;
            iass_pkg::CSR_BACKOFF: backoff_ff     <= csr_write_data;
            iass_pkg::CSR_RETRY:   retry_limit_ff <= csr_write_data[5:0];
            iass_pkg::CSR_DEVADDR: devaddr_ff     <= csr_write_data[7:0];
            iass_pkg::CSR_RATE:    rate_ff        <= csr_write_data[7:0];
            iass_pkg::CSR_CHMASK:  chmask_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= iass_pkg::PH_GETJOB;
         start_ff   <= '0;
         wop_ff     <= 1'b1;
         jwo_ff     <= 1'b0;
         samples_ff <= '0;
         retry_ff   <= '0;
         active_ff  <= iass_pkg::CH_PARK;
         held_ff    <= '0;
      end else if (cmd.commit) begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         wop_ff     <= wop_in;
         jwo_ff     <= jwo_in;
         samples_ff <= samples_in;
         retry_ff   <= retry_in;
         active_ff  <= active_in;
         held_ff    <= held_in;
      end
   end

   // request snapshot and channel candidate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff     <= req_now_ms;
         elapsed_ff <= req_now_ms - start_ff;
         sb_ff      <= req_flag_sb;
         msl_ff     <= req_flag_msl;
         busy_ff    <= req_flag_busy;
         addr_ff    <= req_flag_addr;
         txe_ff     <= req_flag_txe;
         tra_ff     <= req_flag_tra;
         btf_ff     <= req_flag_btf;
         stopf_ff   <= req_flag_stopf;
         rx1_ff     <= req_rx_first;
         rx2_ff     <= req_rx_second;
         cand_ff    <= active_ff;
      end else if (cmd.search_step) begin
         cand_ff    <= cand_nxt;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         o_start_ff <= o_start_in;
         o_stop_ff  <= o_stop_in;
         o_txv_ff   <= o_txv_in;
         o_txb_ff   <= o_txb_in;
         o_ack_ff   <= o_ack_in;
         o_brst_ff  <= o_brst_in;
         o_pins_ff  <= o_pins_in;
         o_mupd_ff  <= o_mupd_in;
         o_mch_ff   <= active_in;
         o_sv_ff    <= o_sv_in;
         o_sch_ff   <= o_sch_in;
         o_sval_ff  <= o_sval_in;
      end
   end

   assign rsp_send_start     = o_start_ff;
   assign rsp_send_stop      = o_stop_ff;
   assign rsp_tx_valid       = o_txv_ff;
   assign rsp_tx_byte        = o_txb_ff;
   assign rsp_ack_off        = o_ack_ff;
   assign rsp_bus_reset      = o_brst_ff;
   assign rsp_pins_reinit    = o_pins_ff;
   assign rsp_mux_update     = o_mupd_ff;
   assign rsp_mux_channel    = o_mch_ff;
   assign rsp_sample_valid   = o_sv_ff;
   assign rsp_sample_channel = o_sch_ff;
   assign rsp_sample_value   = o_sval_ff;

   // active channel is a live channel or the parked value
   `ASSERT_NEVER(a_chan_range, clock, reset, (({1'b0, active_ff} >= 5'(NUM_CHANNELS)) && (active_ff != iass_pkg::CH_PARK)), "active channel out of range")
   // a committed sample belongs to the channel the mux shows
   `ASSERT_PROP(a_sample_chan, clock, reset, (cmd.commit && o_sv_in) |=> (o_sch_ff == o_mch_ff), "sample channel differs from mux channel")

endmodule

>>> hw/rtl/i2c_adc_scan_sequencer.sv
// timing: a request is first taken into the snapshot register; one that starts a new job
//   then runs k (1..NUM_CHANNELS) steps of the one-bit-per-cycle channel search, and the
//   evaluate state commits the step into the response register once that register is
//   free; no new request is taken until that commit
// reset: synchronous, active high; configuration and state registers return to defaults and the scan
//   restarts with the rate write; no memory and no clearing pass
module i2c_adc_scan_sequencer #(
   parameter int NUM_CHANNELS = iass_pkg::NUM_CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_write_enable,
   input  logic [iass_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iass_pkg::CSR_DATA_W-1:0] csr_write_data,
   // poll request: time, master status flags, received bytes
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_now_ms,
   input  logic                            req_flag_sb,
   input  logic                            req_flag_msl,
   input  logic                            req_flag_busy,
   input  logic                            req_flag_addr,
   input  logic                            req_flag_txe,
   input  logic                            req_flag_tra,
   input  logic                            req_flag_btf,
   input  logic                            req_flag_stopf,
   input  logic [7:0]                      req_rx_first,
   input  logic [7:0]                      req_rx_second,
   // command strobes, one response per request
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_send_start,
   output logic                            rsp_send_stop,
   output logic                            rsp_tx_valid,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_ack_off,
   output logic                            rsp_bus_reset,
   output logic                            rsp_pins_reinit,
   output logic                            rsp_mux_update,
   output logic [iass_pkg::CH_W-1:0]       rsp_mux_channel,
   output logic                            rsp_sample_valid,
   output logic [iass_pkg::CH_W-1:0]       rsp_sample_channel,
   output logic [15:0]                     rsp_sample_value
);

   iass_pkg::ctrl_cmd_type    cmd;
   iass_pkg::ctrl_status_type status;

   // controller: request intake, channel search steps, commit into the
   // response register once it is free
   iass_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: csr file, request snapshot, channel search, scan phase logic
   // and response register
   iass_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_now_ms         (req_now_ms),
      .req_flag_sb        (req_flag_sb),
      .req_flag_msl       (req_flag_msl),
      .req_flag_busy      (req_flag_busy),
      .req_flag_addr      (req_flag_addr),
      .req_flag_txe       (req_flag_txe),
      .req_flag_tra       (req_flag_tra),
      .req_flag_btf       (req_flag_btf),
      .req_flag_stopf     (req_flag_stopf),
      .req_rx_first       (req_rx_first),
      .req_rx_second      (req_rx_second),
      .rsp_send_start     (rsp_send_start),
      .rsp_send_stop      (rsp_send_stop),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_ack_off        (rsp_ack_off),
      .rsp_bus_reset      (rsp_bus_reset),
      .rsp_pins_reinit    (rsp_pins_reinit),
      .rsp_mux_update     (rsp_mux_update),
      .rsp_mux_channel    (rsp_mux_channel),
      .rsp_sample_valid   (rsp_sample_valid),
      .rsp_sample_channel (rsp_sample_channel),
      .rsp_sample_value   (rsp_sample_value)
   );

endmodule

>>> sim/scan_step_checker.sv
module scan_step_checker #(
   parameter int NUM_CHANNELS = iass_pkg::NUM_CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [iass_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iass_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [31:0]                     req_now_ms,
   input  logic                            req_flag_sb,
   input  logic                            req_flag_msl,
   input  logic                            req_flag_busy,
   input  logic                            req_flag_addr,
   input  logic                            req_flag_txe,
   input  logic                            req_flag_tra,
   input  logic                            req_flag_btf,
   input  logic                            req_flag_stopf,
   input  logic [7:0]                      req_rx_first,
   input  logic [7:0]                      req_rx_second,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_send_start,
   input  logic                            rsp_send_stop,
   input  logic                            rsp_tx_valid,
   input  logic [7:0]                      rsp_tx_byte,
   input  logic                            rsp_ack_off,
   input  logic                            rsp_bus_reset,
   input  logic                            rsp_pins_reinit,
   input  logic                            rsp_mux_update,
   input  logic [iass_pkg::CH_W-1:0]       rsp_mux_channel,
   input  logic                            rsp_sample_valid,
   input  logic [iass_pkg::CH_W-1:0]       rsp_sample_channel,
   input  logic [15:0]                     rsp_sample_value,
   output int                              fail_count,
   output int                              open_polls,
   output iass_pkg::phase_type             model_phase,
   output logic [31:0]                     model_start
);

   typedef struct packed {
      logic [31:0] now_ms;
      logic        sb;
      logic        msl;
      logic        busy;
      logic        addr;
      logic        txe;
      logic        tra;
      logic        btf;
      logic        stopf;
      logic [7:0]  rx_first;
      logic [7:0]  rx_second;
   } poll_type;

   typedef struct packed {
      logic                      send_start;
      logic                      send_stop;
      logic                      tx_valid;
      logic [7:0]                tx_byte;
      logic                      ack_off;
      logic                      bus_reset;
      logic                      pins_reinit;
      logic                      mux_update;
      logic [iass_pkg::CH_W-1:0] mux_channel;
      logic                      sample_valid;
      logic [iass_pkg::CH_W-1:0] sample_channel;
      logic [15:0]               sample_value;
   } strobe_type;

   // register copies
   logic [15:0] t_timeout, t_settle, t_gap, t_backoff, chan_mask;
   logic [5:0]  retry_cap;
   logic [7:0]  dev_addr, rate_val;

   // sequencer state
   iass_pkg::phase_type       scan_phase;
   logic [31:0]               job_start;
   logic                      rate_write_due, rate_job;
   logic [1:0]                reads_done;
   logic [5:0]                recover_tries;
   logic [iass_pkg::CH_W-1:0] cur_channel;
   logic [15:0]               held_word;

   strobe_type pending_strobes[$];
   strobe_type want;
   int         mismatches = 0;
   int         waiting = 0;

   assign fail_count  = mismatches;
   assign open_polls  = waiting;
   assign model_phase = scan_phase;
   assign model_start = job_start;

   function automatic void enter_recovery();
      if (recover_tries < iass_pkg::RETRY_SAT) recover_tries++;
      scan_phase = iass_pkg::PH_CLEANUP;
   endfunction

   // round-robin search over the enabled channels, empty mask means channel 0
   function automatic void next_channel();
      logic [15:0] m;
      int ch;
      bit found;
      m = chan_mask;
      for (int i = NUM_CHANNELS; i < 16; i++) m[i] = 1'b0;
      if (m == 16'd0) m = 16'd1;
      ch = int'(cur_channel);
      found = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (!found) begin
            ch = ch + 1;
            if (ch >= NUM_CHANNELS) ch = 0;
            found = m[ch];
         end
      end
      cur_channel = ch[iass_pkg::CH_W-1:0];
   endfunction

   // one poll step; phases that chain in one step share the same snapshot
   function automatic strobe_type advance_scan(input poll_type p);
      strobe_type o;
      logic [31:0] elapsed;
      bit held;
      o = '0;
      elapsed = p.now_ms - job_start;
      if (scan_phase != iass_pkg::PH_GETJOB && scan_phase < iass_pkg::PH_CLEANUP
          && elapsed >= 32'(t_timeout)) begin
         o.bus_reset = 1'b1;
         enter_recovery();
      end else begin
         held = 1'b0;
         while (!held) begin
            held = 1'b1;
            case (scan_phase)
               iass_pkg::PH_GETJOB: begin
                  next_channel();
                  o.mux_update = 1'b1;
                  reads_done = 2'd0;
                  job_start = p.now_ms;
                  scan_phase = iass_pkg::PH_GOAGAIN;
                  held = 1'b0;
               end
               iass_pkg::PH_GOAGAIN: begin
                  rate_job = rate_write_due;
                  rate_write_due = 1'b0;
                  scan_phase = iass_pkg::PH_SENDSTART;
                  held = 1'b0;
               end
               iass_pkg::PH_SENDSTART: if (!p.busy) begin
                  scan_phase = iass_pkg::PH_STARTDONE;
                  o.send_start = 1'b1;
                  held = 1'b0;
               end
               iass_pkg::PH_STARTDONE: if (p.sb && p.msl && p.busy) begin
                  o.tx_valid = 1'b1;
                  if (rate_job) begin
                     scan_phase = iass_pkg::PH_WRADDR;
                     o.tx_byte = dev_addr;
                  end else begin
                     scan_phase = iass_pkg::PH_RDADDR;
                     o.tx_byte = dev_addr | 8'h01;
                  end
               end
               iass_pkg::PH_WRADDR: if (p.addr && p.txe && p.msl && p.busy && p.tra) begin
                  scan_phase = iass_pkg::PH_WRRATE;
                  o.tx_valid = 1'b1;
                  o.tx_byte = rate_val;
               end
               iass_pkg::PH_RDADDR: if (p.addr) begin
                  scan_phase = iass_pkg::PH_READ;
                  o.ack_off = 1'b1;
                  held = 1'b0;
               end
               iass_pkg::PH_READ: if (p.btf) begin
                  o.send_stop = 1'b1;
                  held_word = {p.rx_first, p.rx_second};
                  scan_phase = iass_pkg::PH_WAITSTOP;
                  held = 1'b0;
               end
               iass_pkg::PH_WAITSTOP: if (!p.stopf) begin
                  job_start = p.now_ms;
                  scan_phase = iass_pkg::PH_GAP;
                  if (!rate_job) begin
                     if (reads_done < iass_pkg::SAMPLES_SAT) reads_done++;
                     if (reads_done == 2'd1) begin
                        scan_phase = iass_pkg::PH_SETTLE;
                     end else begin
                        o.sample_valid = 1'b1;
                        o.sample_channel = cur_channel;
                        o.sample_value = held_word;
                     end
                  end
               end
               iass_pkg::PH_WRRATE: if (p.btf) begin
                  o.send_stop = 1'b1;
                  scan_phase = iass_pkg::PH_WAITSTOP;
               end
               iass_pkg::PH_SETTLE: if (elapsed >= 32'(t_settle)) begin
                  job_start = p.now_ms;
                  scan_phase = iass_pkg::PH_GOAGAIN;
               end
               iass_pkg::PH_GAP: if (elapsed >= 32'(t_gap)) scan_phase = iass_pkg::PH_GETJOB;
               iass_pkg::PH_BACKOFF: begin
                  if (elapsed >= 32'(t_backoff)) scan_phase = iass_pkg::PH_GETJOB;
               end
               iass_pkg::PH_CLEANUP: begin
                  o.pins_reinit = 1'b1;
                  if (recover_tries < retry_cap && p.busy) begin
                     o.bus_reset = 1'b1;
                     enter_recovery();
                  end else begin
                     scan_phase = iass_pkg::PH_GETJOB;
                     if (recover_tries == retry_cap) begin
                        job_start = p.now_ms;
                        scan_phase = iass_pkg::PH_BACKOFF;
                     end
                     recover_tries = 6'd0;
                     cur_channel = iass_pkg::CH_PARK;
                     rate_write_due = 1'b1;
                  end
               end
               default: scan_phase = iass_pkg::PH_GETJOB;
            endcase
         end
      end
      o.mux_channel = cur_channel;
      return o;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         t_timeout = iass_pkg::TIMEOUT_DEF;
         t_settle = iass_pkg::SETTLE_DEF;
         t_gap = iass_pkg::GAP_DEF;
         t_backoff = iass_pkg::BACKOFF_DEF;
         retry_cap = iass_pkg::RETRY_DEF;
         dev_addr = iass_pkg::DEVADDR_DEF;
         rate_val = iass_pkg::RATE_DEF;
         chan_mask = iass_pkg::CHMASK_DEF;
         scan_phase = iass_pkg::PH_GETJOB;
         job_start = 32'd0;
         rate_write_due = 1'b1;
         rate_job = 1'b0;
         reads_done = 2'd0;
         recover_tries = 6'd0;
         cur_channel = iass_pkg::CH_PARK;
         held_word = 16'd0;
         pending_strobes.delete();
         waiting = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_strobes.size() == 0) begin
               $error("response with no request waiting");
               mismatches++;
            end else begin
               want = pending_strobes.pop_front();
               waiting--;
               compare_field("send_start", 32'(want.send_start), 32'(rsp_send_start));
               compare_field("send_stop", 32'(want.send_stop), 32'(rsp_send_stop));
               compare_field("tx_valid", 32'(want.tx_valid), 32'(rsp_tx_valid));
               compare_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte));
               compare_field("ack_off", 32'(want.ack_off), 32'(rsp_ack_off));
               compare_field("bus_reset", 32'(want.bus_reset), 32'(rsp_bus_reset));
               compare_field("pins_reinit", 32'(want.pins_reinit), 32'(rsp_pins_reinit));
               compare_field("mux_update", 32'(want.mux_update), 32'(rsp_mux_update));
               compare_field("mux_channel", 32'(want.mux_channel), 32'(rsp_mux_channel));
               compare_field("sample_valid", 32'(want.sample_valid), 32'(rsp_sample_valid));
               compare_field("sample_channel", 32'(want.sample_channel),
                             32'(rsp_sample_channel));
               compare_field("sample_value", 32'(want.sample_value), 32'(rsp_sample_value));
            end
         end
         if (csr_write_enable === 1'b1) begin
            case (csr_index)
               iass_pkg::CSR_TIMEOUT: t_timeout = csr_write_data;
               iass_pkg::CSR_SETTLE:  t_settle = csr_write_data;
               iass_pkg::CSR_GAP:     t_gap = csr_write_data;
               iass_pkg::CSR_BACKOFF: t_backoff = csr_write_data;
               iass_pkg::CSR_RETRY:   retry_cap = csr_write_data[5:0];
               iass_pkg::CSR_DEVADDR: dev_addr = csr_write_data[7:0];
               iass_pkg::CSR_RATE:    rate_val = csr_write_data[7:0];
               iass_pkg::CSR_CHMASK:  chan_mask = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            pending_strobes.push_back(advance_scan({req_now_ms, req_flag_sb, req_flag_msl,
               req_flag_busy, req_flag_addr, req_flag_txe, req_flag_tra, req_flag_btf,
               req_flag_stopf, req_rx_first, req_rx_second}));
            waiting++;
         end
      end
   end

endmodule

>>> sim/testbench.sv
module testbench;

   // generous bound for the watchdog on the run length
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int PHASES = 8;
   localparam int DIRECTED_POLLS = 22;
   localparam int POLLS_PER_PHASE = 230;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_enable;
   logic [iass_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [iass_pkg::CSR_DATA_W-1:0] csr_write_data;
   logic                            req_valid;
   logic                            req_stall;
   logic [31:0]                     req_now_ms;
   logic                  req_flag_sb, req_flag_msl, req_flag_busy, req_flag_addr;
   logic                  req_flag_txe, req_flag_tra, req_flag_btf, req_flag_stopf;
   logic [7:0]            req_rx_first, req_rx_second;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_send_start, rsp_send_stop, rsp_tx_valid;
   logic [7:0]            rsp_tx_byte;
   logic                  rsp_ack_off, rsp_bus_reset, rsp_pins_reinit, rsp_mux_update;
   logic [iass_pkg::CH_W-1:0] rsp_mux_channel;
   logic                      rsp_sample_valid;
   logic [iass_pkg::CH_W-1:0] rsp_sample_channel;
   logic [15:0]               rsp_sample_value;

   // from the checker: verdict input, drain count and predicted state for steering
   int                  fail_count;
   int                  open_polls;
   iass_pkg::phase_type model_phase;
   logic [31:0]         model_start;

   // register values as last written, used to aim the time stamps
   logic [15:0] cfg_val [8];

   int unsigned cycle_count = 0;
   int          stall_hold = 0;
   int          calm_left = 0;

   i2c_adc_scan_sequencer dut (.*);
   scan_step_checker step_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side back-pressure: mostly short stalls, a few long ones,
   // and now and then a long stretch with no stall at all
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:2]: begin
               rsp_stall <= 1'b0;
               stall_hold <= $urandom_range(40, 120);
            end
            [3:24]: begin
               rsp_stall <= 1'b1;
               stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(0, 2);
            end
            default: begin
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // time offset around a threshold: just below, at or past it, anywhere
   // up to it, or far away
   function automatic logic [31:0] near_mark(input logic [31:0] mark);
      case ($urandom_range(0, 5))
         0: near_mark = (mark == 32'd0) ? 32'd0 : mark - 32'd1;
         1, 2, 3: near_mark = mark + $urandom_range(0, 20);
         4: near_mark = $urandom_range(0, mark);
         default: near_mark = $urandom;
      endcase
   endfunction

   // one poll request; in tidy mode the flags and the time are chosen to move
   // the predicted phase forward, otherwise they are noise. nth >= 0 marks the
   // directed opening with extreme field values
   task automatic issue_poll(input bit tidy, input int nth);
      logic sb, msl, busy, addr, txe, tra, btf, stopf;
      logic [31:0] now, ofs, tmo;
      logic [7:0] rx1, rx2;
      {sb, msl, busy, addr, txe, tra, btf, stopf} = 8'($urandom);
      tmo = 32'(cfg_val[iass_pkg::CSR_TIMEOUT]);
      case ($urandom_range(0, 7))
         0: rx1 = 8'h00;
         1: rx1 = 8'hFF;
         default: rx1 = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: rx2 = 8'h00;
         1: rx2 = 8'hFF;
         default: rx2 = 8'($urandom);
      endcase
      if (tidy) begin
         case (model_phase)
            iass_pkg::PH_GETJOB, iass_pkg::PH_GOAGAIN, iass_pkg::PH_SENDSTART: busy = 1'b0;
            iass_pkg::PH_STARTDONE: {sb, msl, busy} = 3'b111;
            iass_pkg::PH_WRADDR: {addr, txe, msl, busy, tra} = 5'b11111;
            iass_pkg::PH_WRRATE: btf = 1'b1;
            iass_pkg::PH_RDADDR: begin
               addr = 1'b1;
               stopf = ($urandom_range(0, 3) == 0);
            end
            iass_pkg::PH_READ: begin
               btf = 1'b1;
               stopf = ($urandom_range(0, 3) == 0);
            end
            iass_pkg::PH_WAITSTOP: stopf = 1'b0;
            // mostly busy so that retries pile up toward the limit
            iass_pkg::PH_CLEANUP: busy = ($urandom_range(0, 3) != 0);
            default: ;
         endcase
         case (model_phase)
            iass_pkg::PH_GETJOB, iass_pkg::PH_CLEANUP: ofs = $urandom;
            iass_pkg::PH_SETTLE: begin
               ofs = ($urandom_range(0, 9) == 0) ? near_mark(tmo)
                     : near_mark(32'(cfg_val[iass_pkg::CSR_SETTLE]));
            end
            iass_pkg::PH_GAP: ofs = near_mark(32'(cfg_val[iass_pkg::CSR_GAP]));
            iass_pkg::PH_BACKOFF: ofs = near_mark(32'(cfg_val[iass_pkg::CSR_BACKOFF]));
            default: ofs = ($urandom_range(0, 9) == 0 || tmo == 32'd0) ? near_mark(tmo)
                                                                    : $urandom_range(0, tmo - 1);
         endcase
         now = model_start + ofs;
      end else begin
         now = $urandom_range(0, 1) ? $urandom : model_start + $urandom_range(0, 2 * tmo);
      end
      if (nth == 0) begin
         {sb, msl, busy, addr, txe, tra, btf, stopf} = 8'h00;
         now = 32'd0;
      end else if (nth == 1) begin
         {sb, msl, busy, addr, txe, tra, btf, stopf} = 8'hFF;
         now = 32'hFFFF_FFFF;
      end
      if (nth >= 0) begin
         case (nth % 4)
            0: {rx1, rx2} = 16'hFF00;
            1: {rx1, rx2} = 16'h00FF;
            2: {rx1, rx2} = 16'hFFFF;
            default: {rx1, rx2} = 16'h0000;
         endcase
      end
      req_now_ms <= now;
      req_flag_sb <= sb;
      req_flag_msl <= msl;
      req_flag_busy <= busy;
      req_flag_addr <= addr;
      req_flag_txe <= txe;
      req_flag_tra <= tra;
      req_flag_btf <= btf;
      req_flag_stopf <= stopf;
      req_rx_first <= rx1;
      req_rx_second <= rx2;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   // send a batch of requests with random sender gaps; a directed opening
   // precedes the random part when asked
   task automatic run_phase(input int directed, input int count);
      int g;
      for (int k = 0; k < directed + count; k++) begin
         if (k < directed) issue_poll(1'b1, k);
         else issue_poll($urandom_range(0, 99) < 85, -1);
         if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 99) < 2) begin
            calm_left = $urandom_range(30, 80);
         end else if ($urandom_range(0, 199) == 0) begin
            // hold off until the block has answered everything
            req_valid <= 1'b0;
            do @(negedge clock); while (open_polls != 0);
         end else if ($urandom_range(0, 99) < 30) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            req_valid <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic csr_put(input logic [iass_pkg::CSR_IDX_W-1:0] idx);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= cfg_val[idx];
      @(negedge clock);
   endtask

   // register setting for each phase: the two extreme corners, an out of
   // range corner (zero timeout, zero retry limit, top channel only), then random
   task automatic program_phase(input int ph);
      case (ph)
         1: begin
            cfg_val[iass_pkg::CSR_TIMEOUT] = 16'hFFFF;
            cfg_val[iass_pkg::CSR_SETTLE] = 16'd0;
            cfg_val[iass_pkg::CSR_GAP] = 16'd0;
            cfg_val[iass_pkg::CSR_BACKOFF] = 16'd0;
            cfg_val[iass_pkg::CSR_RETRY] = 16'd63;
            cfg_val[iass_pkg::CSR_DEVADDR] = 16'h00FF;
            cfg_val[iass_pkg::CSR_RATE] = 16'h0000;
            cfg_val[iass_pkg::CSR_CHMASK] = 16'hFFFF;
         end
         2: begin
            cfg_val[iass_pkg::CSR_TIMEOUT] = 16'd1;
            cfg_val[iass_pkg::CSR_SETTLE] = 16'hFFFF;
            cfg_val[iass_pkg::CSR_GAP] = 16'hFFFF;
            cfg_val[iass_pkg::CSR_BACKOFF] = 16'hFFFF;
            cfg_val[iass_pkg::CSR_RETRY] = 16'd1;
            cfg_val[iass_pkg::CSR_DEVADDR] = 16'h0000;
            cfg_val[iass_pkg::CSR_RATE] = 16'h00FF;
            cfg_val[iass_pkg::CSR_CHMASK] = 16'h0000;
         end
         3: begin
            cfg_val[iass_pkg::CSR_TIMEOUT] = 16'd0;
            cfg_val[iass_pkg::CSR_SETTLE] = 16'($urandom_range(0, 50));
            cfg_val[iass_pkg::CSR_GAP] = 16'($urandom_range(0, 50));
            cfg_val[iass_pkg::CSR_BACKOFF] = 16'($urandom_range(0, 100));
            cfg_val[iass_pkg::CSR_RETRY] = 16'd0;
            cfg_val[iass_pkg::CSR_DEVADDR] = 16'($urandom_range(0, 255));
            cfg_val[iass_pkg::CSR_RATE] = 16'($urandom_range(0, 255));
            cfg_val[iass_pkg::CSR_CHMASK] = 16'h8000;
         end
         default: begin
            cfg_val[iass_pkg::CSR_TIMEOUT] = 16'($urandom_range(1, 300));
            cfg_val[iass_pkg::CSR_SETTLE] = 16'($urandom_range(0, 200));
            cfg_val[iass_pkg::CSR_GAP] = 16'($urandom_range(0, 200));
            cfg_val[iass_pkg::CSR_BACKOFF] = 16'($urandom_range(0, 65535));
            // small limits make retry exhaustion and backoff common
            cfg_val[iass_pkg::CSR_RETRY] = 16'($urandom_range(0, 1) ? $urandom_range(1, 4)
                                                                    : $urandom_range(0, 63));
            cfg_val[iass_pkg::CSR_DEVADDR] = 16'($urandom_range(0, 255));
            cfg_val[iass_pkg::CSR_RATE] = 16'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
               0: cfg_val[iass_pkg::CSR_CHMASK] = 16'($urandom_range(0, 65535));
               1: cfg_val[iass_pkg::CSR_CHMASK] = 16'd1 << $urandom_range(0, 15);
               default: cfg_val[iass_pkg::CSR_CHMASK] = 16'd0;
            endcase
         end
      endcase
      csr_put(iass_pkg::CSR_TIMEOUT);
      csr_put(iass_pkg::CSR_SETTLE);
      csr_put(iass_pkg::CSR_GAP);
      csr_put(iass_pkg::CSR_BACKOFF);
      csr_put(iass_pkg::CSR_RETRY);
      csr_put(iass_pkg::CSR_DEVADDR);
      csr_put(iass_pkg::CSR_RATE);
      csr_put(iass_pkg::CSR_CHMASK);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_now_ms = 32'd0;
      {req_flag_sb, req_flag_msl, req_flag_busy, req_flag_addr} = 4'b0000;
      {req_flag_txe, req_flag_tra, req_flag_btf, req_flag_stopf} = 4'b0000;
      req_rx_first = 8'd0;
      req_rx_second = 8'd0;
      cfg_val[iass_pkg::CSR_TIMEOUT] = iass_pkg::TIMEOUT_DEF;
      cfg_val[iass_pkg::CSR_SETTLE] = iass_pkg::SETTLE_DEF;
      cfg_val[iass_pkg::CSR_GAP] = iass_pkg::GAP_DEF;
      cfg_val[iass_pkg::CSR_BACKOFF] = iass_pkg::BACKOFF_DEF;
      cfg_val[iass_pkg::CSR_RETRY] = 16'(iass_pkg::RETRY_DEF);
      cfg_val[iass_pkg::CSR_DEVADDR] = 16'(iass_pkg::DEVADDR_DEF);
      cfg_val[iass_pkg::CSR_RATE] = 16'(iass_pkg::RATE_DEF);
      cfg_val[iass_pkg::CSR_CHMASK] = iass_pkg::CHMASK_DEF;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first phase runs on the reset values, later ones reprogram every register
      // once the block has drained
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            do @(negedge clock); while (open_polls != 0);
            program_phase(ph);
         end
         run_phase(ph == 0 ? DIRECTED_POLLS : 0, ph == 3 ? 120 : POLLS_PER_PHASE);
      end

      do @(negedge clock); while (open_polls != 0);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> i2c_adc_scan_sequencer.f
+incdir+hw/rtl
hw/rtl/iass_pkg.sv
hw/rtl/iass_ctrl.sv
hw/rtl/iass_dp.sv
hw/rtl/i2c_adc_scan_sequencer.sv
sim/scan_step_checker.sv
sim/testbench.sv
